@@ design/hsa_pkg.sv @@
// Shared types, codes and command/status bundles for the handle slot allocator.
`timescale 1ns / 1ps

package hsa_pkg;

	localparam int HSA_SLOTS = 1024;

	localparam int CFG_W    = 11;
	localparam int IDX_W    = 10;
	localparam int UID_W    = 32;
	localparam int STATUS_W = 3;
	localparam int OSLOT_W  = 11;
	localparam int CAP_W    = 11;
	localparam int ID_W     = 31;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [1:0] {
		F_ALLOC = 2'd0,
		F_FREE  = 2'd1,
		F_GET   = 2'd2,
		F_RESET = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		S_OK        = 3'd0,
		S_FULL      = 3'd1,
		S_BAD_INDEX = 3'd2,
		S_STALE     = 3'd3,
		S_NOT_ALIVE = 3'd4
	} status_t;

	typedef enum logic {
		R_INIT_CAP = 1'b0,
		R_MAX_CAP  = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_RST_CLR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic latch;
		logic scan_init;
		logic scan_step;
		logic alloc_hit;
		logic alloc_miss;
		logic rd_issue;
		logic check;
		logic clr_start;
		logic clr_step;
		logic res_bad;
		logic res_rst;
		logic emit;
	} hsa_cmd_t;

	typedef struct packed {
		logic bad_idx;
		logic clr_last;
		logic hit;
		logic exhausted;
		logic out_free;
	} hsa_stat_t;

endpackage

@@ design/hsa_ctrl.sv @@
// Controller state machine of the handle slot allocator.
`timescale 1ns / 1ps

module hsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  hsa_pkg::func_t    func,
	input  hsa_pkg::hsa_stat_t stat,
	output hsa_pkg::hsa_cmd_t cmd
);
	import hsa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_INIT_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					unique case (func)
						F_ALLOC: begin
							cmd.scan_init = 1'b1;
							state_d       = ST_SCAN;
						end
						F_FREE, F_GET: begin
							if (stat.bad_idx) begin
								cmd.res_bad = 1'b1;
								state_d     = ST_EMIT;
							end else begin
								cmd.rd_issue = 1'b1;
								state_d      = ST_CHECK;
							end
						end
						F_RESET: begin
							cmd.clr_start = 1'b1;
							state_d       = ST_RST_CLR;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.hit) begin
					cmd.alloc_hit = 1'b1;
					state_d       = ST_EMIT;
				end else if (stat.exhausted) begin
					cmd.alloc_miss = 1'b1;
					state_d        = ST_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_RST_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					cmd.res_rst = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_INIT_CLR;
		endcase
	end

endmodule

@@ design/hsa_dp.sv @@
// Datapath of the handle slot allocator: slot memory, scan pointer, counters, result words.
`timescale 1ns / 1ps

module hsa_dp #(
	parameter int SLOTS = hsa_pkg::HSA_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic                            wr_index,
	input  logic [hsa_pkg::CFG_W-1:0]       wr_data,
	input  logic [hsa_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hsa_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  hsa_pkg::hsa_cmd_t               cmd,
	output hsa_pkg::hsa_stat_t              stat
);
	import hsa_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = (CW > CFG_W) ? CW : CFG_W;
	localparam int MW = ID_W + 1;

	// Memory word: alive mark on top, uid below.
	logic [MW-1:0] mem [SLOTS];

	logic [CFG_W-1:0] init_cfg_q, max_cfg_q;
	logic [CW-1:0]    cap_q, iss_q;
	logic [IW-1:0]    scan_q, ptr_q, addr_s1;
	logic [ID_W-1:0]  id_q;
	logic             s1_valid_q;
	logic [MW-1:0]    rdata_q;

	logic [1:0]       s_func_q;
	logic [IDX_W-1:0] idx_q;
	logic [UID_W-1:0] uid_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [OSLOT_W-1:0]  res_slot_q;
	logic [UID_W-1:0]    res_uid_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [XW-1:0]    max_x, init_x, eff_max_x, eff_init_x;
	logic [CW-1:0]    eff_max, eff_init, cap_eff;
	logic [IDX_W-1:0] in_idx;
	logic [UID_W-1:0] in_uid;
	logic [CW:0]      dbl;
	logic [CW-1:0]    grown;
	logic             rd_en;
	logic [IW-1:0]    raddr;
	logic             we;
	logic [IW-1:0]    waddr;
	logic [MW-1:0]    wdata;
	logic [UID_W-1:0] stored_uid;
	logic [IW-1:0]    ptr_inc;

	assign in_idx = s_tdata[IDX_W+1:2];
	assign in_uid = s_tdata[UID_W+IDX_W+1:IDX_W+2];

	// Clamp limits to 1..SLOTS; initial is capped at the effective maximum.
	always_comb begin
		max_x  = XW'(max_cfg_q);
		init_x = XW'(init_cfg_q);
		if (max_x == '0) begin
			eff_max_x = XW'(1);
		end else if (max_x > XW'(SLOTS)) begin
			eff_max_x = XW'(SLOTS);
		end else begin
			eff_max_x = max_x;
		end
		if (init_x == '0) begin
			eff_init_x = XW'(1);
		end else if (init_x > XW'(SLOTS)) begin
			eff_init_x = XW'(SLOTS);
		end else begin
			eff_init_x = init_x;
		end
		if (eff_init_x > eff_max_x) begin
			eff_init_x = eff_max_x;
		end
		eff_max  = CW'(eff_max_x);
		eff_init = CW'(eff_init_x);
	end

	assign cap_eff = (cap_q == '0) ? eff_init : cap_q;

	assign dbl   = {cap_q, 1'b0};
	assign grown = (dbl > (CW+1)'(eff_max)) ? eff_max : CW'(dbl);

	assign stored_uid = rdata_q[MW-1] ? UID_W'(rdata_q[ID_W-1:0]) : '1;

	assign ptr_inc = (XW'(ptr_q) + XW'(1) == XW'(cap_q)) ? '0 : IW'(XW'(ptr_q) + XW'(1));

	// One read port: scan pointer while scanning, input index on a free or get.
	always_comb begin
		rd_en = 1'b0;
		raddr = ptr_q;
		if (cmd.rd_issue) begin
			rd_en = 1'b1;
			raddr = IW'(in_idx);
		end else if (cmd.scan_step && (iss_q < cap_q)) begin
			rd_en = 1'b1;
		end
	end

	// One write port.
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.alloc_hit) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = {1'b1, id_q};
		end else if (cmd.alloc_miss && (cap_q < eff_max)) begin
			we    = 1'b1;
			waddr = IW'(cap_q);
			wdata = {1'b1, id_q};
		end else if (cmd.check && (func_t'(s_func_q) == F_FREE) && rdata_q[MW-1]
				&& (stored_uid == uid_q)) begin
			we    = 1'b1;
			waddr = IW'(idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cfg_q <= CFG_W'(16);
			max_cfg_q  <= CFG_W'(1024);
			cap_q      <= '0;
			scan_q     <= '0;
			id_q       <= '0;
			ptr_q      <= '0;
			iss_q      <= '0;
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (reg_index_t'(wr_index))
					R_INIT_CAP: init_cfg_q <= wr_data;
					R_MAX_CAP:  max_cfg_q  <= wr_data;
					default:    init_cfg_q <= init_cfg_q;
				endcase
			end
			if (cmd.latch) begin
				cap_q <= cap_eff;
			end
			if (cmd.clr_start) begin
				ptr_q <= '0;
			end else if (cmd.clr_step) begin
				ptr_q <= stat.clr_last ? '0 : IW'(XW'(ptr_q) + XW'(1));
			end else if (cmd.scan_init) begin
				ptr_q <= scan_q;
				iss_q <= '0;
			end else if (cmd.scan_step && rd_en) begin
				ptr_q <= ptr_inc;
				iss_q <= iss_q + CW'(1);
			end
			s1_valid_q <= cmd.scan_step && rd_en;
			if (cmd.alloc_hit) begin
				id_q <= id_q + ID_W'(1);
			end else if (cmd.alloc_miss && (cap_q < eff_max)) begin
				id_q   <= id_q + ID_W'(1);
				cap_q  <= grown;
				scan_q <= IW'(cap_q);
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload and result words.
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			addr_s1 <= ptr_q;
		end
		if (cmd.latch) begin
			s_func_q <= s_tdata[1:0];
			idx_q    <= in_idx;
			uid_q    <= in_uid;
		end
		if (cmd.res_bad) begin
			res_status_q <= S_BAD_INDEX;
			res_slot_q   <= '1;
			res_uid_q    <= '1;
		end else if (cmd.res_rst) begin
			res_status_q <= S_OK;
			res_slot_q   <= '1;
			res_uid_q    <= '1;
		end else if (cmd.alloc_hit) begin
			res_status_q <= S_OK;
			res_slot_q   <= OSLOT_W'(addr_s1);
			res_uid_q    <= UID_W'(id_q);
		end else if (cmd.alloc_miss) begin
			if (cap_q < eff_max) begin
				res_status_q <= S_OK;
				res_slot_q   <= OSLOT_W'(cap_q);
				res_uid_q    <= UID_W'(id_q);
			end else begin
				res_status_q <= S_FULL;
				res_slot_q   <= '1;
				res_uid_q    <= '1;
			end
		end else if (cmd.check) begin
			if (func_t'(s_func_q) == F_GET) begin
				res_status_q <= S_OK;
				res_slot_q   <= OSLOT_W'(idx_q);
				res_uid_q    <= stored_uid;
			end else if (stored_uid != uid_q) begin
				res_status_q <= S_STALE;
				res_slot_q   <= '1;
				res_uid_q    <= '1;
			end else if (!rdata_q[MW-1]) begin
				res_status_q <= S_NOT_ALIVE;
				res_slot_q   <= '1;
				res_uid_q    <= '1;
			end else begin
				res_status_q <= S_OK;
				res_slot_q   <= OSLOT_W'(idx_q);
				res_uid_q    <= uid_q;
			end
		end
		if (cmd.emit) begin
			m_tdata_q <= {7'd0, CAP_W'(cap_q), res_uid_q, res_slot_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.bad_idx   = XW'(in_idx) >= XW'(cap_eff);
	assign stat.clr_last  = XW'(ptr_q) == XW'(SLOTS - 1);
	assign stat.hit       = s1_valid_q && !rdata_q[MW-1];
	assign stat.exhausted = (iss_q == cap_q) && !s1_valid_q;
	assign stat.out_free  = !m_tvalid_q || m_tready;

endmodule

@@ design/handle_slot_allocator.sv @@
// Top level of the handle slot allocator: controller plus datapath.
`timescale 1ns / 1ps

// Hands out handles (slot index plus a 31-bit wrapping unique id) from a slot
// memory of SLOTS words, and frees, looks up and bulk-clears them. One word in
// on the slave side gives exactly one word out on the master side; words are
// handled one at a time. After reset the block runs a clearing pass over the
// slot memory, one slot per cycle, with s_tready low; configuration writes are
// taken during that time as always. Allocate scans the slots in use from the
// scan start with one memory read per cycle and stops at the first dead slot;
// when every slot is alive it grows the capacity and takes the first new slot,
// or reports full at the maximum. Reset-all rewrites every slot through the
// single write port. The output register holds a finished word while the next
// word is taken in. Write the capacity registers only while the block is idle;
// the initial capacity is taken once, by the first word after reset.
module handle_slot_allocator #(
	parameter int SLOTS = hsa_pkg::HSA_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration: index 0 initial_capacity, index 1 max_capacity.
	input  logic                           wr_en,
	input  logic                           wr_index,
	input  logic [hsa_pkg::CFG_W-1:0]      wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// func[1:0], slot_index[11:2], handle_uid[43:12], zero fill above
	input  logic [hsa_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[2:0], out_slot[13:3], out_uid[45:14], capacity_now[56:46], zero fill above
	output logic [hsa_pkg::OUT_DATA_W-1:0] m_tdata
);
	import hsa_pkg::*;

	hsa_cmd_t  cmd;
	hsa_stat_t stat;

	// Sequence each word: accept, scan, read or clear, decide, emit.
	hsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (func_t'(s_tdata[1:0])),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold slot memory, capacity, scan start, id counter and the output word.
	hsa_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
